FILE: hdl/lfbd_pkg.sv
// ----------------------------------------------------------------------------
// lfbd_pkg
// Shared constants and types of the length-framed byte deframer.
// ----------------------------------------------------------------------------
package lfbd_pkg;

    localparam logic [7:0]  HEADER_BYTE      = 8'h24;
    localparam logic [7:0]  FOOTER_BYTE      = 8'h25;
    localparam logic [14:0] MAX_LENGTH_RESET = 15'd10000;
    localparam logic [15:0] TYPE_INDEX       = 16'd5;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef struct packed {
        logic        frame_good;
        logic        frame_end;
        logic [7:0]  frame_type;
        logic [31:0] good_frames;
        logic [31:0] ticks_since_good;
    } result_t;

endpackage

FILE: hdl/lfbd_core.sv
// ----------------------------------------------------------------------------
// lfbd_core
// Frame hunt state and counters; result of the current input is combinational.
// ----------------------------------------------------------------------------
module lfbd_core
    import lfbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic        action,
    input  logic [7:0]  data_byte,
    input  logic [14:0] max_length,
    output result_t     result
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN_LOW,
        PH_LEN_HIGH,
        PH_BODY
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  length_low_reg, length_low_next;
    logic [14:0] frame_length_reg, frame_length_next;
    logic [15:0] byte_index_reg, byte_index_next;
    logic [7:0]  type_byte_reg, type_byte_next;
    logic [31:0] good_count_reg, good_count_next;
    logic [31:0] tick_count_reg, tick_count_next;

    logic [15:0] len;
    logic        len_bad;
    logic        close;
    logic [7:0]  close_type;
    logic        is_footer;
    logic [16:0] footer_index;

    assign len          = {data_byte, length_low_reg};
    assign len_bad      = data_byte[7] || (len[14:0] > max_length);
    assign is_footer    = (data_byte == FOOTER_BYTE);
    assign footer_index = {2'b00, frame_length_reg} + 17'd2;

    always_comb
    begin
        phase_next        = phase_reg;
        length_low_next   = length_low_reg;
        frame_length_next = frame_length_reg;
        byte_index_next   = byte_index_reg;
        type_byte_next    = type_byte_reg;
        good_count_next   = good_count_reg;
        tick_count_next   = tick_count_reg;
        close             = 1'b0;
        close_type        = 8'd0;

        if (action == ACT_TICK)
        begin
            if (tick_count_reg != '1)
                tick_count_next = tick_count_reg + 32'd1;
        end
        else
        begin
            unique case (phase_reg)
                PH_LEN_LOW:
                begin
                    length_low_next = data_byte;
                    phase_next      = PH_LEN_HIGH;
                end
                PH_LEN_HIGH:
                begin
                    if (len_bad)
                    begin
                        // rescan the two length bytes for a header
                        if (length_low_reg == HEADER_BYTE)
                        begin
                            length_low_next = data_byte;
                            phase_next      = PH_LEN_HIGH;
                        end
                        else
                            phase_next = (data_byte == HEADER_BYTE) ? PH_LEN_LOW : PH_HUNT;
                    end
                    else
                    begin
                        frame_length_next = len[14:0];
                        type_byte_next    = 8'd0;
                        if (len == 16'd0)
                        begin
                            byte_index_next = 16'd2;
                            close           = 1'b1;
                            close_type      = 8'd0;
                        end
                        else
                        begin
                            byte_index_next = 16'd3;
                            phase_next      = PH_BODY;
                        end
                    end
                end
                PH_BODY:
                begin
                    if (byte_index_reg == TYPE_INDEX)
                        type_byte_next = data_byte;
                    if ({1'b0, byte_index_reg} == footer_index)
                    begin
                        close      = 1'b1;
                        close_type = (byte_index_reg == TYPE_INDEX) ? data_byte : type_byte_reg;
                    end
                    else
                        byte_index_next = byte_index_reg + 16'd1;
                end
                default:
                    phase_next = (data_byte == HEADER_BYTE) ? PH_LEN_LOW : PH_HUNT;
            endcase

            if (close)
            begin
                if (is_footer)
                begin
                    good_count_next = good_count_reg + 32'd1;
                    tick_count_next = 32'd0;
                    phase_next      = PH_HUNT;
                end
                else
                    // a wrong footer may itself open the next frame
                    phase_next = (data_byte == HEADER_BYTE) ? PH_LEN_LOW : PH_HUNT;
            end
        end
    end

    assign result.frame_end        = close;
    assign result.frame_good       = close && is_footer;
    assign result.frame_type       = close_type;
    assign result.good_frames      = good_count_next;
    assign result.ticks_since_good = tick_count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT;
            length_low_reg   <= 8'd0;
            frame_length_reg <= 15'd0;
            byte_index_reg   <= 16'd0;
            type_byte_reg    <= 8'd0;
            good_count_reg   <= 32'd0;
            tick_count_reg   <= 32'd0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            length_low_reg   <= length_low_next;
            frame_length_reg <= frame_length_next;
            byte_index_reg   <= byte_index_next;
            type_byte_reg    <= type_byte_next;
            good_count_reg   <= good_count_next;
            tick_count_reg   <= tick_count_next;
        end
    end

endmodule

FILE: hdl/length_framed_byte_deframer.sv
// ----------------------------------------------------------------------------
// length_framed_byte_deframer
// Finds header/length/footer frames in a byte stream, counts good frames
// and timer ticks since the last good frame.
// ----------------------------------------------------------------------------
// Throughput: 1 item per cycle while the skid buffer is empty; an output register
// plus a one-entry skid buffer keep s_tready registered and let input flow while
// a result waits, and each accepted result is registered in one of the two.
// Reset: asynchronous, active low; hunting for a header, counters zero,
// max_length back to 10000, no result pending.
module length_framed_byte_deframer
    import lfbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [14:0] cfg_wdata,      // max_length

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,        // data_byte
    input  logic        s_tuser,        // action

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,        // frame_type, good_frames, ticks_since_good
    output logic        m_tlast,        // frame_end
    output logic        m_tuser         // frame_good
);

    logic [14:0] max_length_reg;
    logic        accept;
    result_t     result;

    logic        out_valid_reg;
    result_t     out_reg;
    logic        skid_valid_reg;
    result_t     skid_reg;

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_length_reg <= MAX_LENGTH_RESET;
        else if (cfg_we)
            max_length_reg <= cfg_wdata;
    end

    lfbd_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .action     (s_tuser),
        .data_byte  (s_tdata),
        .max_length (max_length_reg),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || m_tready)
            begin
                // output slot frees up: take skid first, else new result
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                    out_valid_reg <= accept;
            end
            else if (accept)
                skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept)
                out_reg <= result;
        end
        if (accept && out_valid_reg && !m_tready)
            skid_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.ticks_since_good, out_reg.good_frames, out_reg.frame_type};
    assign m_tlast  = out_reg.frame_end;
    assign m_tuser  = out_reg.frame_good;

    a_good_implies_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame_good without frame_end");

    a_type_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tdata[7:0] == 8'd0)
        else $error("frame_type nonzero outside frame end");

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds data while output register empty");

    a_good_clears_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        accept && result.frame_good |-> result.ticks_since_good == 32'd0)
        else $error("good frame did not clear tick count");

endmodule

FILE: verif/length_framed_byte_deframer_test.sv
// ----------------------------------------------------------------------------
// length_framed_byte_deframer_test
// Self-checking bench for the frame deframer. Streams directed and random
// link bytes and timer ticks through the slave port. It predicts every result
// from its own copy of the hunt/length/body state and the counters, and
// compares each result transaction field by field. max_length is rewritten
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module length_framed_byte_deframer_test;
    import lfbd_pkg::*;

    typedef enum logic [1:0] {
        SCAN_HUNT,
        SCAN_LEN_LO,
        SCAN_LEN_HI,
        SCAN_BODY
    } scan_phase_t;

    typedef struct packed {
        logic       act;
        logic [7:0] data;
    } link_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [14:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    link_item_t  link_q[$];
    result_t     deframed_q[$];
    logic [7:0]  directed_q[$];
    int          errors = 0;
    int          cyc = 0;
    bit          in_taken = 0;
    bit          send_hold = 0;

    // predictor state
    logic [14:0] m_max = MAX_LENGTH_RESET;
    scan_phase_t m_phase = SCAN_HUNT;
    logic [7:0]  m_len_lo = '0;
    logic [14:0] m_flen = '0;
    logic [15:0] m_idx = '0;
    logic [7:0]  m_type = '0;
    logic [31:0] m_good = '0;
    logic [31:0] m_ticks = '0;

    length_framed_byte_deframer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #6 clk = ~clk;

    // -------------------------------------------------------------- predictor
    task automatic close_attempt(input logic [7:0] b, inout result_t r);
        r.frame_end  = 1'b1;
        r.frame_type = m_type;
        if (b == FOOTER_BYTE)
        begin
            r.frame_good = 1'b1;
            m_good       = m_good + 32'd1;
            m_ticks      = '0;
            m_phase      = SCAN_HUNT;
        end
        else
        begin
            m_phase = (b == HEADER_BYTE) ? SCAN_LEN_LO : SCAN_HUNT;
        end
    endtask

    task automatic deframe_step(input logic act, input logic [7:0] b, output result_t r);
        logic [15:0] len;
        r = '0;
        if (act == ACT_TICK)
        begin
            if (m_ticks != '1)
                m_ticks = m_ticks + 32'd1;
        end
        else
        begin
            case (m_phase)
                SCAN_LEN_LO:
                begin
                    m_len_lo = b;
                    m_phase  = SCAN_LEN_HI;
                end
                SCAN_LEN_HI:
                begin
                    len = {b, m_len_lo};
                    if (len[15] || len > {1'b0, m_max})
                    begin
                        // rejected length: low byte may itself be a header
                        if (m_len_lo == HEADER_BYTE)
                            m_len_lo = b;
                        else
                            m_phase = (b == HEADER_BYTE) ? SCAN_LEN_LO : SCAN_HUNT;
                    end
                    else
                    begin
                        m_flen = len[14:0];
                        m_type = '0;
                        if (len == 16'd0)
                        begin
                            m_idx = 16'd2;
                            close_attempt(b, r);
                        end
                        else
                        begin
                            m_idx   = 16'd3;
                            m_phase = SCAN_BODY;
                        end
                    end
                end
                SCAN_BODY:
                begin
                    if (m_idx == TYPE_INDEX)
                        m_type = b;
                    if (m_idx == {1'b0, m_flen} + 16'd2)
                        close_attempt(b, r);
                    else
                        m_idx = m_idx + 16'd1;
                end
                default:
                    m_phase = (b == HEADER_BYTE) ? SCAN_LEN_LO : SCAN_HUNT;
            endcase
        end
        r.good_frames      = m_good;
        r.ticks_since_good = m_ticks;
    endtask

    // ------------------------------------------------------------- stimulus
    task automatic queue_item(input logic act, input logic [7:0] b);
        link_item_t it;
        it.act  = act;
        it.data = b;
        link_q.push_back(it);
    endtask

    task automatic queue_directed();
        foreach (directed_q[i])
            queue_item(ACT_BYTE, directed_q[i]);
    endtask

    task automatic queue_frame(input logic [14:0] lim);
        int         len;
        int         pick;
        logic [7:0] foot;
        bit         chained;
        chained = 0;
        do
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                len = $urandom_range(12);
            else if (pick < 95)
                len = $urandom_range(40, 13);
            else
                len = $urandom_range(300, 41);
            if (len > lim)
                len = $urandom_range(lim);
            if (!chained)
                queue_item(ACT_BYTE, HEADER_BYTE);
            queue_item(ACT_BYTE, len[7:0]);
            queue_item(ACT_BYTE, len[15:8]);
            if (len > 0)
            begin
                for (int i = 3; i <= len + 1; i++)
                begin
                    if ($urandom_range(99) < 8)
                        queue_item(ACT_TICK, 8'($urandom));
                    queue_item(ACT_BYTE, 8'($urandom));
                end
                pick = $urandom_range(99);
                if (pick < 85)
                    foot = FOOTER_BYTE;
                else if (pick < 90)
                    foot = HEADER_BYTE;
                else
                    foot = 8'($urandom);
                queue_item(ACT_BYTE, foot);
                // a wrong footer equal to the header opens the next frame
                chained = (foot == HEADER_BYTE);
            end
            else
            begin
                chained = 0;
            end
        end
        while (chained);
    endtask

    task automatic queue_traffic(input int n, input logic [14:0] lim);
        int         goal;
        int         pick;
        logic [7:0] lo;
        logic [7:0] hi;
        goal = link_q.size() + n;
        while (link_q.size() < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                queue_frame(lim);
            end
            else if (pick < 75)
            begin
                // broken header: length rejected for bit 15 or above the limit
                lo = ($urandom_range(99) < 30) ? HEADER_BYTE : 8'($urandom);
                if (lim < 15'h2400 && lo != HEADER_BYTE && $urandom_range(1))
                    hi = HEADER_BYTE;
                else
                    hi = 8'($urandom_range(255, 128));
                queue_item(ACT_BYTE, HEADER_BYTE);
                queue_item(ACT_BYTE, lo);
                queue_item(ACT_BYTE, hi);
                if (lo == HEADER_BYTE)
                    queue_item(ACT_BYTE, 8'($urandom_range(255, 128)));
            end
            else if (pick < 90)
            begin
                repeat ($urandom_range(4, 1))
                begin
                    lo = 8'($urandom);
                    queue_item(ACT_BYTE, (lo == HEADER_BYTE) ? ~lo : lo);
                end
            end
            else
            begin
                queue_item(ACT_TICK, 8'($urandom));
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (link_q.size() != 0 || s_tvalid || deframed_q.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_max_length(input logic [14:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // --------------------------------------------------------------- driver
    always @(negedge clk)
    begin : drive_link
        link_item_t nxt;
        bit         calm;
        calm = (cyc >= 600 && cyc < 1100);
        if (rst_n)
        begin
            if (!s_tvalid || in_taken)
            begin
                if (link_q.size() != 0 && !send_hold && (calm || $urandom_range(99) >= 17))
                begin
                    nxt = link_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data;
                    s_tuser  <= nxt.act;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            in_taken = 0;
            m_tready <= calm || $urandom_range(99) >= 17;
        end
    end

    // -------------------------------------------------------------- monitor
    always @(posedge clk)
    begin : check_results
        result_t want;
        result_t got;
        cyc = cyc + 1;
        if (rst_n)
        begin
            if (cfg_we)
                m_max = cfg_wdata;
            if (m_tvalid && m_tready)
            begin
                got.frame_end        = m_tlast;
                got.frame_good       = m_tuser;
                got.frame_type       = m_tdata[7:0];
                got.good_frames      = m_tdata[39:8];
                got.ticks_since_good = m_tdata[71:40];
                if (deframed_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result transaction at cycle %0d", cyc);
                end
                else
                begin
                    want = deframed_q.pop_front();
                    if (got.frame_end !== want.frame_end
                        || got.frame_good !== want.frame_good
                        || got.frame_type !== want.frame_type
                        || got.good_frames !== want.good_frames
                        || got.ticks_since_good !== want.ticks_since_good)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"cycle %0d: exp end=%0d good=%0d type=%h frames=%0d",
                                      " ticks=%0d, got end=%0d good=%0d type=%h frames=%0d",
                                      " ticks=%0d"}, cyc,
                                     want.frame_end, want.frame_good, want.frame_type,
                                     want.good_frames, want.ticks_since_good,
                                     got.frame_end, got.frame_good, got.frame_type,
                                     got.good_frames, got.ticks_since_good);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                deframe_step(s_tuser, s_tdata, want);
                deframed_q.push_back(want);
                in_taken = 1;
            end
        end
    end

    // ------------------------------------------------------------- sequence
    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: tick, zero length, good frame with type, wrong footer
        // that opens a new frame, and a doubly rejected length
        queue_item(ACT_TICK, 8'hFF);
        directed_q = {8'h24, 8'h00, 8'h00};
        queue_directed();
        directed_q = {8'h24, 8'h04, 8'h00, 8'h11, 8'h22, 8'hC3, 8'h25};
        queue_directed();
        directed_q = {8'h24, 8'h01, 8'h00, 8'h24, 8'h02, 8'h00};
        queue_directed();
        queue_item(ACT_TICK, 8'h00);
        queue_item(ACT_BYTE, 8'h5A);
        queue_item(ACT_BYTE, FOOTER_BYTE);
        directed_q = {8'h24, 8'h24, 8'hFF, 8'hFF};
        queue_directed();
        queue_traffic(300, MAX_LENGTH_RESET);
        wait_drained();

        write_max_length(15'h7FFF);
        queue_traffic(350, 15'h7FFF);
        wait_drained();

        write_max_length(15'd0);
        queue_traffic(300, 15'd0);
        wait_drained();

        // sender holds off until every pending result has drained
        write_max_length(15'd5);
        queue_traffic(175, 15'd5);
        do
            @(posedge clk);
        while (link_q.size() != 0);
        send_hold = 1;
        queue_traffic(175, 15'd5);
        do
            @(posedge clk);
        while (s_tvalid || deframed_q.size() != 0);
        send_hold = 0;
        wait_drained();

        begin : last_phase
            logic [14:0] lim;
            lim = 15'($urandom_range(600, 6));
            write_max_length(lim);
            queue_traffic(350, lim);
        end
        wait_drained();

        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #2400000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
